// File: hdl/assert_macros.svh
// Assertion macros used by the checker file lsh_checker.sv.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is masked while reset is asserted.
`define LSH_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define LSH_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hdl/lsh_pkg.sv
// Shared types, constants and register indexes of the RGB Laplacian sharpen block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lsh_pkg;

    localparam int MAX_WIDTH_DEF    = 1024;
    localparam int QUEUE_DEPTH_DEF  = 4;

    localparam int FW_W             = 11;
    localparam int FH_W             = 13;
    localparam int CFG_IDX_W        = 1;
    localparam int CFG_DATA_W       = 13;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    localparam logic [7:0] PIX_MAX = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef struct packed {
        logic emit;
        logic interior;
        logic last;
    } t_cmd_flags;

endpackage

`default_nettype wire

// File: hdl/lsh_if.sv
// Stream interfaces for the pixel request channel and the result channel.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface lsh_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;

    modport source (output valid, kind, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, kind, red_in, green_in, blue_in, output ready);
endinterface

interface lsh_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_last;

    modport source (output valid, red_out, green_out, blue_out, frame_last, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, frame_last, output ready);
endinterface

`default_nettype wire

// File: hdl/lsh_ram.sv
// Generic single-write, single-read RAM with registered, enabled read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lsh_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hdl/lsh_front.sv
// Front end: accepts requests, holds the frame registers and stream counters,
// and turns each kept request into a line-store command. Uses lsh_pkg and lsh_in_if.
`timescale 1ns / 1ps
`default_nettype none

module lsh_front import lsh_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int CW       = $clog2(MAX_WIDTH)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    lsh_in_if.sink                i_pix,
    input  logic                  i_q_ready,
    output logic                  o_push,
    output logic [CW-1:0]         o_col,
    output t_rgb                  o_px,
    output t_cmd_flags            o_flags
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int EW = (WW > FW_W) ? WW : FW_W;
    localparam int RW = FH_W + 1;

    logic [FW_W-1:0] r_frame_width,  n_frame_width;
    logic [FH_W-1:0] r_frame_height, n_frame_height;
    logic [CW-1:0]   r_in_col,  n_in_col;
    logic [RW-1:0]   r_in_row,  n_in_row;
    logic [CW-1:0]   r_out_col, n_out_col;
    logic [FH_W-1:0] r_out_row, n_out_row;

    logic [EW-1:0]   fw_e;
    logic [WW-1:0]   eff_w;
    logic [FH_W-1:0] eff_h;
    logic            in_frame;
    logic            take;
    logic [CW-1:0]   col;
    logic [WW-1:0]   col_p1;
    logic [WW-1:0]   oc_p1;
    logic [RW-1:0]   or_p1;
    logic            emit;
    logic            interior;
    logic            last;

    assign i_pix.ready = i_q_ready;

    always_comb begin
        fw_e  = EW'(r_frame_width);
        eff_w = WW'((fw_e == '0) ? EW'(1) :
                    ((fw_e > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : fw_e));
        eff_h = (r_frame_height == '0) ? FH_W'(1) : r_frame_height;

        in_frame = r_in_row < RW'(eff_h);
        take     = i_pix.valid && i_pix.ready && !(in_frame && i_pix.kind);

        col    = (WW'(r_in_col) >= eff_w) ? CW'(eff_w - WW'(1)) : r_in_col;
        col_p1 = WW'(col) + WW'(1);
        emit   = (r_in_row >= RW'(2)) || ((r_in_row == RW'(1)) && (col != '0));

        oc_p1    = WW'(r_out_col) + WW'(1);
        or_p1    = RW'(r_out_row) + RW'(1);
        interior = (r_out_row != '0) && (or_p1 < RW'(eff_h)) &&
                   (r_out_col != '0) && (oc_p1 < eff_w);
        last     = (or_p1 >= RW'(eff_h)) && (oc_p1 >= eff_w);
    end

    always_comb begin
        n_frame_width  = r_frame_width;
        n_frame_height = r_frame_height;
        n_in_col       = r_in_col;
        n_in_row       = r_in_row;
        n_out_col      = r_out_col;
        n_out_row      = r_out_row;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_FRAME_WIDTH:  n_frame_width  = i_cfg_data[FW_W-1:0];
                CFG_FRAME_HEIGHT: n_frame_height = i_cfg_data[FH_W-1:0];
            endcase
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end else if (take) begin
            if (col_p1 >= eff_w) begin
                n_in_col = '0;
                n_in_row = r_in_row + RW'(1);
            end else begin
                n_in_col = CW'(col_p1);
            end
            if (emit) begin
                priority if (last) begin
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_out_col = '0;
                    n_out_row = '0;
                end else if (oc_p1 >= eff_w) begin
                    n_out_col = '0;
                    n_out_row = FH_W'(or_p1);
                end else begin
                    n_out_col = CW'(oc_p1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
            r_in_col       <= '0;
            r_in_row       <= '0;
            r_out_col      <= '0;
            r_out_row      <= '0;
        end else begin
            r_frame_width  <= n_frame_width;
            r_frame_height <= n_frame_height;
            r_in_col       <= n_in_col;
            r_in_row       <= n_in_row;
            r_out_col      <= n_out_col;
            r_out_row      <= n_out_row;
        end
    end

    assign o_push  = take;
    assign o_col   = col;
    assign o_px    = in_frame ? t_rgb'({i_pix.red_in, i_pix.green_in, i_pix.blue_in}) : '0;
    assign o_flags = '{emit: emit, interior: interior, last: last};

endmodule

`default_nettype wire

// File: hdl/lsh_queue.sv
// Small register FIFO that decouples the front end from the back end.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lsh_queue #(
    parameter int DW    = 37,
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    output logic          o_ready,
    output logic          o_valid,
    output logic [DW-1:0] o_data,
    input  logic          i_pop
);

    localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNW = $clog2(DEPTH + 1);

    logic [DW-1:0]  r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNW-1:0] r_count,  n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_ready = r_count != CNW'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

// File: hdl/lsh_back.sv
// Back end: line stores, 3x3 window, sharpen arithmetic and output register.
// Uses lsh_pkg, lsh_out_if and lsh_ram.
`timescale 1ns / 1ps
`default_nettype none

module lsh_back import lsh_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int CW       = $clog2(MAX_WIDTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  logic [CW-1:0] i_q_col,
    input  t_rgb          i_q_px,
    input  t_cmd_flags    i_q_flags,
    output logic          o_q_pop,
    lsh_out_if.source     o_pix
);

    function automatic logic [7:0] sharpen(input logic [8:0][7:0] taps);
        logic [11:0]        nine_c;
        logic [11:0]        nsum;
        logic signed [12:0] acc;
        nine_c = 12'({taps[4], 3'b000}) + 12'(taps[4]);
        nsum   = '0;
        for (int i = 0; i < 9; i++) begin
            if (i != 4) begin
                nsum = nsum + 12'(taps[i]);
            end
        end
        acc = $signed({1'b0, nine_c}) - $signed({1'b0, nsum});
        if (acc[12]) begin
            sharpen = '0;
        end else if (acc > $signed(13'(PIX_MAX))) begin
            sharpen = PIX_MAX;
        end else begin
            sharpen = acc[7:0];
        end
    endfunction

    logic          r_s2_valid;
    logic [CW-1:0] r_s2_col;
    t_rgb          r_s2_px;
    t_cmd_flags    r_s2_flags;
    logic          r_fwd;
    t_rgb          r_fwd_up;
    t_rgb          r_fwd_mid;

    t_rgb r_win [3][3];
    t_rgb n_win [3][3];

    logic r_o_valid;
    t_rgb r_o_px;
    logic r_o_last;

    t_rgb up_rdata, mid_rdata;
    t_rgb s2_up, s2_mid;
    logic out_free;
    logic s2_fire;
    logic pop;

    logic [8:0][7:0] taps_r, taps_g, taps_b;
    t_rgb            result;

    assign out_free = !r_o_valid || o_pix.ready;
    assign s2_fire  = r_s2_valid && (!r_s2_flags.emit || out_free);
    assign pop      = i_q_valid && (!r_s2_valid || s2_fire);
    assign o_q_pop  = pop;

    assign s2_up  = r_fwd ? r_fwd_up  : up_rdata;
    assign s2_mid = r_fwd ? r_fwd_mid : mid_rdata;

    lsh_ram #(.WIDTH($bits(t_rgb)), .DEPTH(MAX_WIDTH)) u_upper (
        .i_clk   (i_clk),
        .i_we    (s2_fire),
        .i_waddr (r_s2_col),
        .i_wdata (s2_mid),
        .i_re    (pop),
        .i_raddr (i_q_col),
        .o_rdata (up_rdata)
    );

    lsh_ram #(.WIDTH($bits(t_rgb)), .DEPTH(MAX_WIDTH)) u_middle (
        .i_clk   (i_clk),
        .i_we    (s2_fire),
        .i_waddr (r_s2_col),
        .i_wdata (r_s2_px),
        .i_re    (pop),
        .i_raddr (i_q_col),
        .o_rdata (mid_rdata)
    );

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[r][0] = r_win[r][1];
            n_win[r][1] = r_win[r][2];
        end
        n_win[0][2] = s2_up;
        n_win[1][2] = s2_mid;
        n_win[2][2] = r_s2_px;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                taps_r[r*3+c] = n_win[r][c].red;
                taps_g[r*3+c] = n_win[r][c].green;
                taps_b[r*3+c] = n_win[r][c].blue;
            end
        end
        if (r_s2_flags.interior) begin
            result = '{red: sharpen(taps_r), green: sharpen(taps_g), blue: sharpen(taps_b)};
        end else begin
            result = n_win[1][1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_fwd      <= 1'b0;
            r_o_valid  <= 1'b0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else begin
            if (pop) begin
                r_s2_valid <= 1'b1;
                // same column still being written back: take its data directly
                r_fwd      <= s2_fire && (i_q_col == r_s2_col);
            end else if (s2_fire) begin
                r_s2_valid <= 1'b0;
            end
            if (s2_fire) begin
                r_win <= n_win;
            end
            if (s2_fire && r_s2_flags.emit) begin
                r_o_valid <= 1'b1;
            end else if (o_pix.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_s2_col   <= i_q_col;
            r_s2_px    <= i_q_px;
            r_s2_flags <= i_q_flags;
            r_fwd_up   <= s2_mid;
            r_fwd_mid  <= r_s2_px;
        end
        if (s2_fire && r_s2_flags.emit) begin
            r_o_px   <= result;
            r_o_last <= r_s2_flags.last;
        end
    end

    assign o_pix.valid      = r_o_valid;
    assign o_pix.red_out    = r_o_px.red;
    assign o_pix.green_out  = r_o_px.green;
    assign o_pix.blue_out   = r_o_px.blue;
    assign o_pix.frame_last = r_o_last;

endmodule

`default_nettype wire

// File: hdl/rgb_laplacian_sharpen_3x3.sv
// RGB 3x3 Laplacian sharpen, top level.
// Depends on lsh_pkg, lsh_if, lsh_front, lsh_queue and lsh_back.
//
// Usage:
//   i_pix carries raster-order requests: kind 0 is a pixel, kind 1 a drain
//   request. Send frame_width*frame_height pixels, then frame_width+1 drain
//   requests; drain requests sent while the frame is still incoming are dropped.
//   o_pix returns one result per image pixel, border pixels unchanged, interior
//   pixels sharpened and clamped; frame_last marks the final pixel.
//   i_cfg_we/i_cfg_idx/i_cfg_data write frame_width (0) and frame_height (1);
//   a write restarts the frame. Write only while the block is idle.
// Timing:
//   Throughput is one request per cycle unless the output stalls, set by the line
//   stores, which take one read and one write per pixel on separate ports in the
//   back end. A result leaves once the request one line plus one pixel later in
//   the stream has passed queue, line-store read, window/sharpen and output register.
// Reset:
//   Counters, window and handshakes clear; line stores are not cleared, since
//   unwritten entries only reach border pixels. No clearing pass.
// Stall:
//   A stalled output holds its result; the back end stops, the front queue
//   fills and i_pix.ready drops once it is full.
`timescale 1ns / 1ps
`default_nettype none

module rgb_laplacian_sharpen_3x3 import lsh_pkg::*; #(
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    lsh_in_if.sink                i_pix,
    lsh_out_if.source             o_pix
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int QW = CW + $bits(t_rgb) + $bits(t_cmd_flags);

    logic          push;
    logic [CW-1:0] f_col;
    t_rgb          f_px;
    t_cmd_flags    f_flags;
    logic          q_ready;
    logic          q_valid;
    logic [QW-1:0] q_data;
    logic          q_pop;

    lsh_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (i_pix),
        .i_q_ready  (q_ready),
        .o_push     (push),
        .o_col      (f_col),
        .o_px       (f_px),
        .o_flags    (f_flags)
    );

    lsh_queue #(.DW(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_col, f_px, f_flags}),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_data),
        .i_pop   (q_pop)
    );

    lsh_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_col   (q_data[QW-1 -: CW]),
        .i_q_px    (q_data[$bits(t_cmd_flags) +: $bits(t_rgb)]),
        .i_q_flags (q_data[$bits(t_cmd_flags)-1:0]),
        .o_q_pop   (q_pop),
        .o_pix     (o_pix)
    );

endmodule

`default_nettype wire

// File: hdl/lsh_checker.sv
// Port-level checker for the sharpen block and its bind to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lsh_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_red,
    input logic [7:0] i_green,
    input logic [7:0] i_blue,
    input logic       i_last
);

    `LSH_ASSERT_ALWAYS(a_no_result_after_reset, i_clk, !i_rst_n |=> !i_out_valid, "result valid right after reset")
    `LSH_ASSERT_ALWAYS(a_ready_after_reset, i_clk, !i_rst_n |=> i_in_ready, "request channel not ready after reset")
    `LSH_ASSERT(a_result_held, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "stalled result dropped")
    `LSH_ASSERT(a_payload_held, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> $stable({i_red, i_green, i_blue, i_last}), "stalled result changed")

endmodule

bind rgb_laplacian_sharpen_3x3 lsh_checker u_lsh_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_red       (o_pix.red_out),
    .i_green     (o_pix.green_out),
    .i_blue      (o_pix.blue_out),
    .i_last      (o_pix.frame_last)
);

`default_nettype wire
